### sv/sas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite animation sequencer package
// Shared types, codes and constants of the sprite animation sequencer.
// ----------------------------------------------------------------------------
package sas_pkg;

  localparam int DEF_FRAME_ENTRIES = 16;

  localparam int SPRITE_W   = 10;
  localparam int TICKS_W    = 8;
  localparam int ENTRY_W    = SPRITE_W + TICKS_W;
  localparam int FIDX_W     = 5;
  localparam int WIDE_IDX_W = 9;
  localparam int TIMER_W    = 16;
  localparam int SPEED_W    = 10;
  localparam int SPEED_SHIFT = 6;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int DIV_STEPS  = 16;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_LOAD   = 2'd1,
    OP_START  = 2'd2,
    OP_SETDUR = 2'd3
  } sas_op_e;

  localparam logic [1:0] MODE_STOP = 2'd0;
  localparam logic [1:0] MODE_LOOP = 2'd1;
  localparam logic [1:0] MODE_ONCE = 2'd2;
  localparam logic [1:0] MODE_HIDE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANIM_SPEED  = 2'd2;

  localparam logic [2:0] EV_LAST_TICK = 3'b001;
  localparam logic [2:0] EV_FINISHED  = 3'b010;
  localparam logic [2:0] EV_ADVANCED  = 3'b100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DSTART,
    ST_DWAIT,
    ST_READ1,
    ST_FIN
  } sas_state_e;

endpackage
`default_nettype wire

### sv/sas_frame_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame table memory
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module sas_frame_mem
  import sas_pkg::*;
#(
  parameter int FRAME_ENTRIES = DEF_FRAME_ENTRIES,
  localparam int AW = $clog2(FRAME_ENTRIES)
) (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [AW-1:0]      waddr_i,
  input  wire logic [ENTRY_W-1:0] wdata_i,
  input  wire logic               re_i,
  input  wire logic [AW-1:0]      raddr_i,
  output logic      [ENTRY_W-1:0] rdata_o
);

  logic [ENTRY_W-1:0] mem_q [FRAME_ENTRIES];
  logic [ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### sv/sas_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timer rescale divider
// Radix-4 restoring divider, 32-bit dividend by 16-bit divisor.
// ----------------------------------------------------------------------------
module sas_divider
  import sas_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [2*TIMER_W-1:0]   dividend_i,
  input  wire logic [TIMER_W-1:0]     divisor_i,
  output logic                        done_o,
  output logic      [2*TIMER_W-1:0]   quotient_o
);

  localparam int SW = 3 * TIMER_W;

  logic [TIMER_W-1:0]   rem_q, rem_d;
  logic [2*TIMER_W-1:0] qr_q, qr_d;
  logic [3:0]           cnt_q, cnt_d;
  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [SW-1:0]        s1, s2;

  function automatic logic [SW-1:0] div_step(input logic [SW-1:0] s,
                                             input logic [TIMER_W-1:0] d);
    logic [TIMER_W:0] r;
    logic [TIMER_W:0] rs;
    begin
      r  = {s[SW-1:2*TIMER_W], s[2*TIMER_W-1]};
      rs = r - {1'b0, d};
      if (r >= {1'b0, d}) begin
        div_step = {rs[TIMER_W-1:0], s[2*TIMER_W-2:0], 1'b1};
      end else begin
        div_step = {r[TIMER_W-1:0], s[2*TIMER_W-2:0], 1'b0};
      end
    end
  endfunction

  assign s1 = div_step({rem_q, qr_q}, divisor_i);
  assign s2 = div_step(s1, divisor_i);

  always_comb begin
    rem_d  = rem_q;
    qr_d   = qr_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      qr_d  = dividend_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = s2[SW-1:2*TIMER_W];
      qr_d  = s2[2*TIMER_W-1:0];
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'(DIV_STEPS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    qr_q  <= qr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = qr_q;

endmodule
`default_nettype wire

### sv/sprite_animation_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite animation sequencer
// Frame table driven animation sequencer with loop, once and hide modes.
// ----------------------------------------------------------------------------
// Tick, load and start items go via ST_EXEC, ST_READ1 and ST_FIN to the result.
// A set-duration item also waits in ST_DSTART and ST_DWAIT on the radix-4 divider.
// Each item reads the frame table twice through its single read port.
// The next item is taken in the cycle its result is strobed; results cannot stall.
// Reset clears control state; output registers and frame table are not cleared.
module sprite_animation_sequencer
  import sas_pkg::*;
#(
  parameter int FRAME_ENTRIES = DEF_FRAME_ENTRIES
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            opcode_i,
  input  wire logic [3:0]            entry_index_i,
  input  wire logic [SPRITE_W-1:0]   sprite_number_i,
  input  wire logic [TICKS_W-1:0]    frame_ticks_i,
  input  wire logic [1:0]            play_mode_i,
  input  wire logic [TIMER_W-1:0]    duration_value_i,
  output logic                       done_o,
  output logic                       show_sprite_o,
  output logic      [SPRITE_W-1:0]   shown_sprite_o,
  output logic      [1:0]            shown_mode_o,
  output logic      [2:0]            events_o,
  output logic                       finished_o,
  output logic                       hidden_o,
  output logic      [3:0]            current_frame_o
);

  localparam int AW = $clog2(FRAME_ENTRIES);
  localparam logic [WIDE_IDX_W-1:0] ENTRIES_W = WIDE_IDX_W'(FRAME_ENTRIES);

  sas_state_e state_q, state_d;

  logic [FIDX_W-1:0]  frame_count_q;
  logic               reverse_q;
  logic [SPEED_W-1:0] speed_q;

  sas_op_e             op_q, op_d;
  logic [3:0]          entry_q, entry_d;
  logic [SPRITE_W-1:0] sprite_q, sprite_d;
  logic [TICKS_W-1:0]  ticks_q, ticks_d;
  logic [1:0]          pm_q, pm_d;
  logic [TIMER_W-1:0]  dv_q, dv_d;

  logic [1:0]          mode_q, mode_d;
  logic [FIDX_W-1:0]   frame_idx_q, frame_idx_d;
  logic [TIMER_W-1:0]  timer_q, timer_d;
  logic [TIMER_W-1:0]  dur_q, dur_d;
  logic [2:0]          ev_q, ev_d;
  logic                hide_q, hide_d;

  logic                show_q, show_d;
  logic                fin_q, fin_d;
  logic                adv_q, adv_d;
  logic [SPRITE_W-1:0] sprite_before_q, sprite_before_d;
  logic [1:0]          mode_before_q, mode_before_d;
  logic [2*TIMER_W-1:0] prod_q, prod_d;

  logic                out_we;
  logic                done_q;
  logic                show_out_q;
  logic [SPRITE_W-1:0] shown_out_q;
  logic [1:0]          mode_out_q;
  logic [2:0]          ev_out_q;
  logic                fin_out_q;
  logic                hide_out_q;
  logic [3:0]          frame_out_q;

  logic                mem_we;
  logic                mem_re;
  logic [AW-1:0]       mem_waddr;
  logic [AW-1:0]       mem_raddr;
  logic [ENTRY_W-1:0]  mem_wdata;
  logic [ENTRY_W-1:0]  mem_rdata;

  logic                 div_start;
  logic                 div_done;
  logic [2*TIMER_W-1:0] div_quo;

  logic [FIDX_W-1:0]     fc_nz;
  logic [FIDX_W-1:0]     cnt;
  logic [FIDX_W-1:0]     cnt_m1;
  logic [WIDE_IDX_W-1:0] load_wide;
  logic [WIDE_IDX_W-1:0] frame_wide;
  logic                  load_ok;
  logic [TIMER_W-1:0]    t_inc;
  logic [TIMER_W:0]      t_inc1;
  logic [FIDX_W:0]       idx_p1;
  logic                  at_end;
  logic [FIDX_W-1:0]     idx_step;
  logic [TICKS_W+SPEED_W-1:0] scaled;
  logic [TICKS_W+SPEED_W-SPEED_SHIFT-1:0] scaled_sh;
  logic [TIMER_W-1:0]    dur_calc;

  assign fc_nz  = (frame_count_q == '0) ? FIDX_W'(1) : frame_count_q;
  assign cnt    = ({4'b0, fc_nz} > ENTRIES_W) ? ENTRIES_W[FIDX_W-1:0] : fc_nz;
  assign cnt_m1 = cnt - FIDX_W'(1);

  assign load_wide  = {5'b0, entry_q};
  assign frame_wide = {4'b0, frame_idx_q};
  assign load_ok    = load_wide < ENTRIES_W;

  assign t_inc  = (timer_q != TIMER_MAX) ? timer_q + TIMER_W'(1) : timer_q;
  assign t_inc1 = {1'b0, t_inc} + (TIMER_W+1)'(1);
  assign idx_p1 = {1'b0, frame_idx_q} + (FIDX_W+1)'(1);
  assign at_end = reverse_q ? (frame_idx_q == '0) : (idx_p1 >= {1'b0, cnt});
  assign idx_step = reverse_q ? (frame_idx_q - FIDX_W'(1)) : idx_p1[FIDX_W-1:0];

  assign scaled    = (TICKS_W+SPEED_W)'(mem_rdata[ENTRY_W-1:SPRITE_W])
                   * (TICKS_W+SPEED_W)'(speed_q);
  assign scaled_sh = scaled[TICKS_W+SPEED_W-1:SPEED_SHIFT];
  assign dur_calc  = (scaled_sh == '0) ? TIMER_W'(1) : TIMER_W'(scaled_sh);

  assign mem_waddr = load_wide[AW-1:0];
  assign mem_raddr = frame_wide[AW-1:0];
  assign mem_wdata = {ticks_q, sprite_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FIDX_W'(1);
      reverse_q     <= 1'b0;
      speed_q       <= SPEED_W'(64);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_COUNT: frame_count_q <= cfg_data_i[FIDX_W-1:0];
        CFG_REVERSE:     reverse_q     <= cfg_data_i[0];
        CFG_ANIM_SPEED:  speed_q       <= cfg_data_i[SPEED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d         = state_q;
    op_d            = op_q;
    entry_d         = entry_q;
    sprite_d        = sprite_q;
    ticks_d         = ticks_q;
    pm_d            = pm_q;
    dv_d            = dv_q;
    mode_d          = mode_q;
    frame_idx_d     = frame_idx_q;
    timer_d         = timer_q;
    dur_d           = dur_q;
    ev_d            = ev_q;
    hide_d          = hide_q;
    show_d          = show_q;
    fin_d           = fin_q;
    adv_d           = adv_q;
    sprite_before_d = sprite_before_q;
    mode_before_d   = mode_before_q;
    prod_d          = prod_q;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    div_start       = 1'b0;
    out_we          = 1'b0;
    busy            = (state_q != ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_d          = sas_op_e'(opcode_i);
          entry_d       = entry_index_i;
          sprite_d      = sprite_number_i;
          ticks_d       = frame_ticks_i;
          pm_d          = play_mode_i;
          dv_d          = (duration_value_i == '0) ? TIMER_W'(1) : duration_value_i;
          mode_before_d = mode_q;
          mem_re        = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        sprite_before_d = mem_rdata[SPRITE_W-1:0];
        show_d          = 1'b0;
        fin_d           = 1'b0;
        adv_d           = 1'b0;
        state_d         = ST_READ1;
        case (op_q)
          OP_TICK: begin
            if (mode_q != MODE_STOP) begin
              ev_d    = '0;
              show_d  = (timer_q == '0);
              timer_d = t_inc;
              if (t_inc >= dur_q) begin
                adv_d   = 1'b1;
                timer_d = '0;
                if (at_end) begin
                  fin_d = 1'b1;
                  ev_d  = EV_FINISHED;
                  if (reverse_q) begin
                    frame_idx_d = frame_idx_q;
                  end else begin
                    frame_idx_d = cnt_m1;
                  end
                  if (mode_q == MODE_ONCE) begin
                    mode_d = MODE_STOP;
                  end else if (mode_q == MODE_HIDE) begin
                    mode_d = MODE_STOP;
                    hide_d = 1'b1;
                  end else begin
                    frame_idx_d = reverse_q ? cnt_m1 : '0;
                    ev_d        = EV_FINISHED | EV_ADVANCED;
                  end
                end else begin
                  frame_idx_d = idx_step;
                  ev_d        = EV_ADVANCED;
                end
              end else if (t_inc1 >= {1'b0, dur_q}) begin
                if (at_end) begin
                  ev_d = EV_LAST_TICK;
                end
              end
            end
          end
          OP_LOAD: begin
            mem_we = load_ok;
          end
          OP_START: begin
            mode_d      = pm_q;
            frame_idx_d = ({1'b0, entry_q} >= cnt) ? cnt_m1 : {1'b0, entry_q};
            timer_d     = '0;
            dur_d       = dv_q;
            ev_d        = '0;
            hide_d      = 1'b0;
          end
          OP_SETDUR: begin
            prod_d  = (2*TIMER_W)'(dv_q) * (2*TIMER_W)'(timer_q);
            state_d = ST_DSTART;
          end
          default: begin
          end
        endcase
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_d   = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          timer_d = (div_quo[2*TIMER_W-1:TIMER_W] != '0) ? TIMER_MAX
                                                         : div_quo[TIMER_W-1:0];
          dur_d   = dv_q;
          state_d = ST_READ1;
        end
      end
      ST_READ1: begin
        mem_re  = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (adv_q) begin
          dur_d = dur_calc;
        end
        out_we  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_STOP;
      frame_idx_q <= '0;
      timer_q     <= '0;
      dur_q       <= TIMER_W'(1);
      ev_q        <= '0;
      hide_q      <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      frame_idx_q <= frame_idx_d;
      timer_q     <= timer_d;
      dur_q       <= dur_d;
      ev_q        <= ev_d;
      hide_q      <= hide_d;
      done_q      <= out_we;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q            <= op_d;
    entry_q         <= entry_d;
    sprite_q        <= sprite_d;
    ticks_q         <= ticks_d;
    pm_q            <= pm_d;
    dv_q            <= dv_d;
    show_q          <= show_d;
    fin_q           <= fin_d;
    adv_q           <= adv_d;
    sprite_before_q <= sprite_before_d;
    mode_before_q   <= mode_before_d;
    prod_q          <= prod_d;
    if (out_we) begin
      show_out_q  <= show_q;
      shown_out_q <= show_q ? sprite_before_q : mem_rdata[SPRITE_W-1:0];
      mode_out_q  <= mode_before_q;
      ev_out_q    <= ev_q;
      fin_out_q   <= fin_q;
      hide_out_q  <= hide_q;
      frame_out_q <= frame_idx_q[3:0];
    end
  end

  sas_frame_mem #(
    .FRAME_ENTRIES(FRAME_ENTRIES)
  ) u_frame_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  sas_divider u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(prod_q),
    .divisor_i (dur_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  assign done_o          = done_q;
  assign show_sprite_o   = show_out_q;
  assign shown_sprite_o  = shown_out_q;
  assign shown_mode_o    = mode_out_q;
  assign events_o        = ev_out_q;
  assign finished_o      = fin_out_q;
  assign hidden_o        = hide_out_q;
  assign current_frame_o = frame_out_q;

`ifndef SYNTH
  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while an item is in progress");

  a_short_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i != OP_SETDUR) |-> ##4 done_o)
    else $error("result of a short item not strobed after four cycles");

  a_finish_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && finished_o) |-> events_o[1])
    else $error("finished result without the finished event");

  a_index_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {4'b0, frame_idx_q} < ENTRIES_W)
    else $error("frame index beyond the frame table");

  a_div_in_setdur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DWAIT))
    else $error("divider finished outside a set-duration item");
`endif

endmodule
`default_nettype wire
